[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the matrix chain deformer.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WMCD_ASSERT(lbl, prp, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prp) else $error(msg);
`define WMCD_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define WMCD_ASSERT(lbl, prp, msg)
`define WMCD_NEVER(lbl, cond, msg)
`endif
`endif

[hw/rtl/wmcd_pkg.sv]
// Types, constants and helpers of the weighted matrix chain deformer.
// No dependencies.
`default_nettype none
package wmcd_pkg;
    localparam int NUM_STAGES_DEF = 4;
    localparam int COORD_BITS = 32;
    localparam int NUM_WEIGHTS = 4;
    localparam int COEFS_PER_STAGE = 12;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [1:0] CFG_ACTIVE_STAGES = 2'd0;
    localparam logic [1:0] CFG_REVERSE_ORDER = 2'd1;
    localparam logic [1:0] CFG_ENVELOPE = 2'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DEFORM = 1'b1;

    typedef struct packed {
        logic        action;
        logic [5:0]  coef_slot;
        logic [31:0] coef_value;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [16:0] weight_0;
        logic [16:0] weight_1;
        logic [16:0] weight_2;
        logic [16:0] weight_3;
    } item_t;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
    } result_t;

    // A point in flight with the weights it still needs.
    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] pos;
        logic [NUM_WEIGHTS-1:0][16:0] weight;
    } point_t;

    // Per-slot control, to be kept fixed by the user while the block is busy; the block does not enforce it.
    typedef struct packed {
        logic       act;
        logic [2:0] sidx;
    } slot_ctl_t;

    function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            return hi[COORD_BITS-1:0];
        else if (v < lo)
            return lo[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction
endpackage
`default_nettype wire

[hw/rtl/wmcd_chan.sv]
// Valid/ready channel carrying one payload of type T.
// Used with wmcd_pkg::item_t and wmcd_pkg::result_t.
`default_nettype none
interface wmcd_chan #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/wmcd_slot.sv]
// One stage of the matrix chain: affine product, saturate, weighted blend.
// Four register steps; depends on wmcd_pkg.
`default_nettype none
module wmcd_slot
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire logic                  valid_in,
    input  wire wmcd_pkg::point_t      pt_in,
    input  wire wmcd_pkg::slot_ctl_t   ctl,
    input  wire logic [11:0][31:0]     coef,
    output logic                       valid_out,
    output wmcd_pkg::point_t           pt_out,
    output logic                       busy
);
    localparam int CB = wmcd_pkg::COORD_BITS;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    wmcd_pkg::point_t     pt1_reg, pt2_reg, pt3_reg, pt4_reg, pt4_next;
    logic signed [63:0]   prod_reg [3][3];
    logic signed [63:0]   prod_next [3][3];
    logic [2:0][31:0]     tr_reg;
    logic [16:0]          w1_reg, w2_reg, w_next;
    logic                 a1_reg, a2_reg, a3_reg;
    logic [2:0][CB-1:0]   t_reg, t_next;
    logic signed [50:0]   dw_reg [3];
    logic signed [50:0]   dw_next [3];

    always_comb
    begin
        logic [16:0] wr;
        for (int j = 0; j < 3; j++)
            for (int k = 0; k < 3; k++)
                prod_next[j][k] = $signed(pt_in.pos[k]) * $signed(coef[k*3+j]);
        if (ctl.sidx < 3'(wmcd_pkg::NUM_WEIGHTS))
            wr = pt_in.weight[ctl.sidx[1:0]];
        else
            wr = '0;
        w_next = (wr > wmcd_pkg::ONE_Q16) ? wmcd_pkg::ONE_Q16 : wr;
    end

    // Sum of the three products, each shifted right by 16, and the translation, then saturate.
    always_comb
    begin
        logic signed [51:0] s;
        for (int j = 0; j < 3; j++)
        begin
            s = 52'(prod_reg[j][0] >>> 16) + 52'(prod_reg[j][1] >>> 16)
                + 52'(prod_reg[j][2] >>> 16) + 52'($signed(tr_reg[j]));
            t_next[j] = wmcd_pkg::sat_coord(64'(s));
        end
    end

    always_comb
    begin
        logic signed [CB:0] d;
        logic signed [17:0] ws;
        ws = $signed({1'b0, w2_reg});
        for (int j = 0; j < 3; j++)
        begin
            d = (CB+1)'($signed(t_reg[j])) - (CB+1)'($signed(pt2_reg.pos[j]));
            dw_next[j] = 51'(d) * 51'(ws);
        end
    end

    always_comb
    begin
        logic signed [63:0] np;
        pt4_next = pt3_reg;
        for (int j = 0; j < 3; j++)
        begin
            np = 64'($signed(pt3_reg.pos[j])) + 64'(dw_reg[j] >>> 16);
            if (a3_reg)
                pt4_next.pos[j] = wmcd_pkg::sat_coord(np);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            tr_reg   <= {coef[11], coef[10], coef[9]};
            pt1_reg  <= pt_in;
            w1_reg   <= w_next;
            a1_reg   <= ctl.act;
            t_reg    <= t_next;
            pt2_reg  <= pt1_reg;
            w2_reg   <= w1_reg;
            a2_reg   <= a1_reg;
            dw_reg   <= dw_next;
            pt3_reg  <= pt2_reg;
            a3_reg   <= a2_reg;
            pt4_reg  <= pt4_next;
        end
    end

    assign valid_out = v4_reg;
    assign pt_out    = pt4_reg;
    assign busy      = v1_reg | v2_reg | v3_reg | v4_reg;
endmodule
`default_nettype wire

[hw/rtl/weighted_matrix_chain_deform.sv]
// Weighted affine matrix chain deformer, top level.
// Point items pass through NUM_STAGES slots of four register steps each.
// The items channel carries load and deform items; the results channel
// carries one deformed point per deform item, none per load.
// A point passes through the register steps of each slot in turn between
// its transfer and the earliest transfer of its result. Throughput: one
// point per cycle while results are taken and no load waits, set by the
// pipeline of slots, each with nine 32x32 multipliers and three blend
// multipliers. A load item waits until no point is in flight in the slots,
// then writes its coefficient; a point behind it sees the new coefficient.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken at once.
// Reset clears the registers to active_stages 0, reverse_order 0 and
// envelope one; the coefficient store is undefined until loaded.
// When the receiver holds results.ready low with a result shown, the whole
// pipeline freezes and items.ready drops; nothing is lost or repeated.
// Inactive slots, and all slots at zero envelope, pass points unchanged.
`default_nettype none
`include "assert_macros.svh"
module weighted_matrix_chain_deform
#(
    parameter int NUM_STAGES = wmcd_pkg::NUM_STAGES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    wmcd_chan.sink           items,
    wmcd_chan.source         results,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);
    localparam int SW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int DEPTH = NUM_STAGES * wmcd_pkg::COEFS_PER_STAGE;

    logic [2:0]  active_reg;
    logic        reverse_reg;
    logic [16:0] envelope_reg;
    logic [11:0][31:0] mat_reg [NUM_STAGES];

    logic              adv;
    logic              in_busy;
    logic              load_go;
    logic [3:0]        n_eff;
    logic [NUM_STAGES:0] vchain;
    wmcd_pkg::point_t  pchain [NUM_STAGES+1];
    logic [NUM_STAGES-1:0] busy_vec;
    wmcd_pkg::item_t   it;

    assign it      = items.data;
    assign adv     = !results.valid || results.ready;
    assign in_busy = |busy_vec;
    assign items.ready = adv && (it.action == wmcd_pkg::ACT_DEFORM || !in_busy);
    assign load_go = items.valid && items.ready && it.action == wmcd_pkg::ACT_LOAD;
    assign n_eff   = ({1'b0, active_reg} > 4'(NUM_STAGES)) ? 4'(NUM_STAGES)
                                                          : {1'b0, active_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            reverse_reg  <= 1'b0;
            envelope_reg <= wmcd_pkg::ONE_Q16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wmcd_pkg::CFG_ACTIVE_STAGES: active_reg   <= cfg_data[2:0];
                wmcd_pkg::CFG_REVERSE_ORDER: reverse_reg  <= cfg_data[0];
                wmcd_pkg::CFG_ENVELOPE:      envelope_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < NUM_STAGES; b++)
            for (int e = 0; e < wmcd_pkg::COEFS_PER_STAGE; e++)
                if (load_go && 7'(it.coef_slot) == 7'(b * 12 + e)
                    && 7'(it.coef_slot) < 7'(DEPTH))
                    mat_reg[b][e] <= it.coef_value;
    end

    // Coordinate k of the point sits at pos[k]: x at 0, z at 2.
    assign vchain[0] = items.valid && items.ready && it.action == wmcd_pkg::ACT_DEFORM;
    always_comb
    begin
        pchain[0].pos    = {it.pos_z, it.pos_y, it.pos_x};
        pchain[0].weight = {it.weight_3, it.weight_2, it.weight_1, it.weight_0};
    end

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_slot
        wmcd_pkg::slot_ctl_t ctl;
        logic [3:0] sfull;
        always_comb
        begin
            sfull    = reverse_reg ? (n_eff - 4'd1 - 4'(i)) : 4'(i);
            ctl.act  = (4'(i) < n_eff) && (envelope_reg != '0);
            ctl.sidx = ctl.act ? sfull[2:0] : 3'(i);
        end
        wmcd_slot u_slot
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (vchain[i]),
            .pt_in     (pchain[i]),
            .ctl       (ctl),
            .coef      (mat_reg[ctl.sidx[SW-1:0]]),
            .valid_out (vchain[i+1]),
            .pt_out    (pchain[i+1]),
            .busy      (busy_vec[i])
        );
    end

    assign results.valid      = vchain[NUM_STAGES];
    assign results.data.out_x = pchain[NUM_STAGES].pos[0];
    assign results.data.out_y = pchain[NUM_STAGES].pos[1];
    assign results.data.out_z = pchain[NUM_STAGES].pos[2];

    `WMCD_ASSERT(a_load_when_empty, (load_go |-> !in_busy), "load transfer with points in flight")
    `WMCD_ASSERT(a_stall_blocks, (results.valid && !results.ready |-> !items.ready), "input open during stall")
    `WMCD_ASSERT(a_point_enters, (vchain[0] |=> busy_vec[0]), "accepted point did not enter first slot")
    `WMCD_NEVER(a_n_range, (n_eff > 4'(NUM_STAGES)), "stage count beyond slots")
endmodule
`default_nettype wire

[tb/tb_weighted_matrix_chain_deform.sv]
// Self-checking testbench of weighted_matrix_chain_deform: a directed table, then random
// phases, every deformed point checked against a fixed-point predictor of the stage chain.
// Depends on wmcd_pkg, the wmcd_chan interface and the block's top level.
module tb_weighted_matrix_chain_deform;
    localparam int STORE_WORDS = wmcd_pkg::NUM_STAGES_DEF * wmcd_pkg::COEFS_PER_STAGE;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 4 * wmcd_pkg::NUM_STAGES_DEF + 8;

    typedef struct {
        bit                  is_cfg;
        logic [1:0]          idx;
        logic [16:0]         val;
        wmcd_pkg::item_t     it;
        bit                  has_exp;
        wmcd_pkg::result_t   exp;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    wmcd_chan #(.T(wmcd_pkg::item_t))   items_if();
    wmcd_chan #(.T(wmcd_pkg::result_t)) res_if();

    weighted_matrix_chain_deform dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_if),
        .results   (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: coefficient store and register copies.
    logic [31:0] coef_mem [STORE_WORDS];
    logic [2:0]  stages_q;
    logic        reverse_q;
    logic [16:0] envelope_q;

    wmcd_pkg::result_t point_q[$];
    row_t              dir_rows[$];
    bit                typed_valid;
    wmcd_pkg::result_t typed_point;
    bit                hold_req;
    int                n_errors;
    int                n_points;
    int                n_loads;
    int                n_checked;
    int                cycles;
    int                burst_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint coef_at(int s, int k);
        return longint'(signed'(coef_mem[s * wmcd_pkg::COEFS_PER_STAGE + k]));
    endfunction

    // Runs one point through the active stages with floor-rounded products.
    function automatic wmcd_pkg::result_t deform_point(wmcd_pkg::item_t it);
        longint p[3];
        longint t[3];
        longint w;
        longint acc;
        int n;
        int s;
        wmcd_pkg::result_t r;
        p[0] = longint'(signed'(it.pos_x));
        p[1] = longint'(signed'(it.pos_y));
        p[2] = longint'(signed'(it.pos_z));
        if (envelope_q != 17'd0)
        begin
            n = (stages_q > wmcd_pkg::NUM_STAGES_DEF) ? wmcd_pkg::NUM_STAGES_DEF
                                                      : int'(stages_q);
            for (int i = 0; i < n; i++)
            begin
                s = reverse_q ? n - 1 - i : i;
                case (s)
                    0: w = longint'(it.weight_0);
                    1: w = longint'(it.weight_1);
                    2: w = longint'(it.weight_2);
                    default: w = longint'(it.weight_3);
                endcase
                if (w > 65536)
                    w = 65536;
                for (int j = 0; j < 3; j++)
                begin
                    acc = coef_at(s, 9 + j);
                    for (int k = 0; k < 3; k++)
                        acc += (p[k] * coef_at(s, k * 3 + j)) >>> 16;
                    t[j] = sat32(acc);
                end
                for (int j = 0; j < 3; j++)
                    p[j] = sat32(p[j] + (((t[j] - p[j]) * w) >>> 16));
            end
        end
        r.out_x = p[0][31:0];
        r.out_y = p[1][31:0];
        r.out_z = p[2][31:0];
        return r;
    endfunction

    function automatic wmcd_pkg::item_t mk_pt(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                              logic [16:0] w0, logic [16:0] w1,
                                              logic [16:0] w2, logic [16:0] w3);
        wmcd_pkg::item_t it;
        it = '0;
        it.action = wmcd_pkg::ACT_DEFORM;
        it.coef_slot = 6'($urandom);
        it.coef_value = $urandom;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.weight_0 = w0;
        it.weight_1 = w1;
        it.weight_2 = w2;
        it.weight_3 = w3;
        return it;
    endfunction

    function automatic wmcd_pkg::item_t mk_ld(logic [5:0] slot, logic [31:0] val);
        wmcd_pkg::item_t it;
        it = mk_pt($urandom, $urandom, $urandom, 17'($urandom), 17'($urandom),
                   17'($urandom), 17'($urandom));
        it.action = wmcd_pkg::ACT_LOAD;
        it.coef_slot = slot;
        it.coef_value = val;
        return it;
    endfunction

    function automatic void append_row(row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic void add_pt(wmcd_pkg::item_t it, bit typed);
        row_t r;
        r = '{default: '0};
        r.it = it;
        r.has_exp = typed;
        r.exp = {it.pos_x, it.pos_y, it.pos_z};
        append_row(r);
    endfunction

    function automatic void add_cfg(logic [1:0] idx, logic [16:0] val);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        append_row(r);
    endfunction

    // Coefficient near the identity so that chained stages stay in range.
    function automatic logic [31:0] tame_coef(int slot);
        int k;
        k = slot % wmcd_pkg::COEFS_PER_STAGE;
        if (k >= 9)
            return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        if (k % 4 == 0)
            return 32'(32'sh10000 + $signed($urandom_range(0, 1 << 15)) - (1 << 14));
        return 32'($signed($urandom_range(0, 1 << 15)) - (1 << 14));
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return wmcd_pkg::ONE_Q16;
            2: return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // Transfers one item; the sender may idle between bursts of random length.
    task automatic send(wmcd_pkg::item_t it, bit typed, wmcd_pkg::result_t exp);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                items_if.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        items_if.valid = 1'b1;
        items_if.data = it;
        typed_valid = typed;
        typed_point = exp;
        do
            @(posedge clk);
        while (!items_if.ready);
        @(negedge clk);
    endtask

    // Lets the pipeline empty: waits until every expected result is taken, then lets the input idle.
    task automatic drain();
        items_if.valid = 1'b0;
        typed_valid = 1'b0;
        while (point_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            wmcd_pkg::CFG_ACTIVE_STAGES: stages_q = val[2:0];
            wmcd_pkg::CFG_REVERSE_ORDER: reverse_q = val[0];
            default: envelope_q = val;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Receiver: stalls in short random runs, with clean stretches and one long hold-off.
    initial
    begin
        int run;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                res_if.ready = 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                res_if.ready = 1'b1;
                run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
                repeat (run - 1) @(negedge clk);
                if ($urandom_range(0, 2) != 0)
                begin
                    @(negedge clk);
                    res_if.ready = 1'b0;
                    repeat ($urandom_range(0, 5)) @(negedge clk);
                end
            end
        end
    end

    // Transfer monitor: predicts at the input, checks at the output.
    always @(posedge clk)
    begin
        wmcd_pkg::result_t want;
        wmcd_pkg::result_t got;
        if (rst_n)
        begin
            cycles++;
            if (cycles > TIMEOUT_CYCLES)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Test completed with failures");
                $finish;
            end
            if (items_if.valid && items_if.ready)
            begin
                if (items_if.data.action == wmcd_pkg::ACT_LOAD)
                begin
                    n_loads++;
                    if (items_if.data.coef_slot < STORE_WORDS)
                        coef_mem[items_if.data.coef_slot] = items_if.data.coef_value;
                end
                else
                begin
                    n_points++;
                    want = deform_point(items_if.data);
                    if (typed_valid && want != typed_point)
                    begin
                        n_errors++;
                        $display("%0t: predictor disagrees with table: exp %h got %h",
                                 $time, typed_point, want);
                    end
                    point_q.insert(point_q.size(), typed_valid ? typed_point : want);
                end
            end
            if (res_if.valid && res_if.ready)
            begin
                got = res_if.data;
                if (point_q.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected result %h", $time, got);
                end
                else
                begin
                    want = point_q.pop_front();
                    n_checked++;
                    if (got.out_x !== want.out_x)
                    begin
                        n_errors++;
                        $display("%0t: out_x exp %h got %h", $time, want.out_x, got.out_x);
                    end
                    if (got.out_y !== want.out_y)
                    begin
                        n_errors++;
                        $display("%0t: out_y exp %h got %h", $time, want.out_y, got.out_y);
                    end
                    if (got.out_z !== want.out_z)
                    begin
                        n_errors++;
                        $display("%0t: out_z exp %h got %h", $time, want.out_z, got.out_z);
                    end
                end
            end
        end
    end

    initial
    begin
        wmcd_pkg::item_t it;
        wmcd_pkg::result_t none;
        logic [16:0] env_pick;
        none = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_if.valid = 1'b0;
        items_if.data = '0;
        typed_valid = 1'b0;
        typed_point = '0;
        hold_req = 1'b0;
        n_errors = 0;
        n_points = 0;
        n_loads = 0;
        n_checked = 0;
        cycles = 0;
        burst_left = 0;
        stages_q = 3'd0;
        reverse_q = 1'b0;
        envelope_q = wmcd_pkg::ONE_Q16;
        foreach (coef_mem[i])
            coef_mem[i] = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Right after reset no stage is active, so points come back as they went in.
        add_pt(mk_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF), 1'b1);
        add_pt(mk_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     17'd0, 17'd0, 17'd0, 17'd0), 1'b1);
        foreach (dir_rows[i])
            send(dir_rows[i].it, dir_rows[i].has_exp, dir_rows[i].exp);
        dir_rows.delete();

        // Fill the whole store before any stage reads it.
        for (int s = 0; s < STORE_WORDS; s++)
            send(mk_ld(6'(s), tame_coef(s)), 1'b0, none);

        add_cfg(wmcd_pkg::CFG_ACTIVE_STAGES, 17'd4);
        add_pt(mk_pt(32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678,
                     17'd0, 17'd0, 17'd0, 17'd0), 1'b1);
        add_pt(mk_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, wmcd_pkg::ONE_Q16,
                     wmcd_pkg::ONE_Q16, wmcd_pkg::ONE_Q16, wmcd_pkg::ONE_Q16), 1'b0);
        add_pt(mk_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF), 1'b0);
        add_pt(mk_pt(32'h0003_8000, 32'hFFF0_0000, 32'h0000_0001,
                     17'd32768, 17'd0, wmcd_pkg::ONE_Q16, 17'd1), 1'b0);
        append_row('{0, 0, 0, mk_ld(6'd63, 32'hFFFF_FFFF), 0, '0});
        append_row('{0, 0, 0, mk_ld(6'd47, 32'h8000_0000), 0, '0});
        add_pt(mk_pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000, wmcd_pkg::ONE_Q16,
                     wmcd_pkg::ONE_Q16, wmcd_pkg::ONE_Q16, wmcd_pkg::ONE_Q16), 1'b0);
        add_cfg(wmcd_pkg::CFG_REVERSE_ORDER, 17'd1);
        add_pt(mk_pt(32'h0005_0000, 32'h0002_0000, 32'hFFFD_0000,
                     17'd65535, 17'd40000, 17'd20000, 17'd1), 1'b0);
        add_cfg(wmcd_pkg::CFG_ACTIVE_STAGES, 17'd7);
        add_pt(mk_pt(32'h0100_0000, 32'hFF00_0000, 32'h0000_FFFF,
                     wmcd_pkg::ONE_Q16, 17'd100, 17'h1FFFF, 17'd30000), 1'b0);
        add_cfg(wmcd_pkg::CFG_ENVELOPE, 17'd0);
        add_pt(mk_pt(32'h7FFF_FFFF, 32'h8000_0000, 32'hDEAD_BEEF, wmcd_pkg::ONE_Q16,
                     wmcd_pkg::ONE_Q16, wmcd_pkg::ONE_Q16, wmcd_pkg::ONE_Q16), 1'b1);
        add_cfg(wmcd_pkg::CFG_ENVELOPE, 17'd1);
        add_pt(mk_pt(32'h0004_0000, 32'h0004_0000, 32'h0004_0000, wmcd_pkg::ONE_Q16,
                     wmcd_pkg::ONE_Q16, wmcd_pkg::ONE_Q16, wmcd_pkg::ONE_Q16), 1'b0);
        add_cfg(wmcd_pkg::CFG_ACTIVE_STAGES, 17'd2);
        add_cfg(wmcd_pkg::CFG_REVERSE_ORDER, 17'd0);
        add_cfg(wmcd_pkg::CFG_ENVELOPE, wmcd_pkg::ONE_Q16);
        add_pt(mk_pt(32'h0002_0000, 32'hFFFE_0000, 32'h0001_0000,
                     17'd50000, wmcd_pkg::ONE_Q16, 17'd0, 17'd0), 1'b0);
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            else
                send(dir_rows[i].it, dir_rows[i].has_exp, dir_rows[i].exp);
        end

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(wmcd_pkg::CFG_ACTIVE_STAGES,
                      (ph == 1) ? 17'd0 : (ph == 5) ? 17'd7
                      : (ph < 4) ? 17'd4 : 17'($urandom_range(1, 4)));
            write_reg(wmcd_pkg::CFG_REVERSE_ORDER, 17'(ph % 2));
            case (ph)
                2: env_pick = 17'd0;
                6: env_pick = 17'($urandom_range(1, 65535));
                default: env_pick = wmcd_pkg::ONE_Q16;
            endcase
            write_reg(wmcd_pkg::CFG_ENVELOPE, env_pick);
            if (ph == 3)
                hold_req = 1'b1;
            for (int i = 0; i < 100; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                        it = mk_ld(6'($urandom), $urandom);
                    else
                    begin
                        it = mk_ld(6'($urandom_range(0, 63)), 32'h0);
                        it.coef_value = tame_coef(it.coef_slot);
                    end
                end
                else
                    it = mk_pt(rand_pos(), rand_pos(), rand_pos(), rand_weight(),
                               rand_weight(), rand_weight(), rand_weight());
                send(it, 1'b0, none);
            end
        end

        drain();
        $display("Covered %0d points and %0d coefficient loads, %0d results checked,",
                 n_points, n_loads, n_checked);
        $display("over all stage counts, both orders, zero and nonzero envelopes.");
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
